// ----- rtl/core/lras_pkg.sv -----
// Shared types and constants for the lazy range-add/range-sum tree.
package lras_pkg;

  localparam int OPC_W = 2;
  localparam int BND_W = 11;
  localparam int VAL_W = 32;
  localparam int SUM_W = 64;
  localparam int IDX_W = 12;

  localparam logic [BND_W-1:0] USED_RST = 11'd1024;

  typedef enum logic [OPC_W-1:0] {
    OP_ADD    = 2'd0,
    OP_SUM    = 2'd1,
    OP_SEEK_R = 2'd2,
    OP_SEEK_L = 2'd3
  } lras_op_t;

endpackage

// ----- rtl/core/lras_if.sv -----
// Valid/ready channel interfaces: command input, result output, length register write.
interface lras_in_if;
  import lras_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [OPC_W-1:0]         opcode;
  logic [BND_W-1:0]         left_bound;
  logic [BND_W-1:0]         right_bound;
  logic signed [VAL_W-1:0]  amount;
  logic signed [VAL_W-1:0]  target;
  modport source (output valid, opcode, left_bound, right_bound, amount, target,
                  input ready);
  modport sink   (input valid, opcode, left_bound, right_bound, amount, target,
                  output ready);
endinterface

interface lras_out_if;
  import lras_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [SUM_W-1:0]  sum_value;
  logic signed [IDX_W-1:0]  found_index;
  modport source (output valid, sum_value, found_index, input ready);
  modport sink   (input valid, sum_value, found_index, output ready);
endinterface

interface lras_cfg_if;
  import lras_pkg::*;
  logic             valid;
  logic             ready;
  logic [BND_W-1:0] used_length;
  modport source (output valid, used_length, input ready);
  modport sink   (input valid, used_length, output ready);
endinterface

// ----- rtl/core/lazy_range_add_sum_tree.sv -----
// Lazy range-add / range-sum tree over SIZE signed 64-bit elements, with prefix searches.
// The tree lives in two single-port-write memories of 2*SIZE words (node sum and an
// unpushed add tag per node, heap order, root at 1). A small sequencer walks the tree
// depth first without a stack: it descends by doubling the node number and moves on by
// stepping to the sibling or climbing one level a cycle. Each node visit goes through
// memory read, one pass through the shared 64 x 12 multiplier (ancestor tag sum times
// node length, or amount times overlap length for an add), and evaluate and write back.
// A node that does not descend is followed by advance steps: to its sibling if it was
// visited first, else one level up per climb step until a sibling or the root is
// reached. An item therefore passes through an accept step, the node visits with their
// advance steps and a result step (held while the output register still holds an unread
// result), with up to roughly 4 nodes per level over log2(SIZE)+1 levels; in_ch.ready is
// low meanwhile. After reset and after every used_length write a clearing pass zeroes
// both memories, node by node, during which no command is accepted. A used_length write is
// taken only while idle or clearing. Range add gives no result; every other opcode
// returns one result transaction, held in an output register.
module lazy_range_add_sum_tree #(
  parameter int SIZE = 1024
) (
  input  logic   clk,
  input  logic   rst_n,
  lras_in_if.sink    in_ch,
  lras_out_if.source out_ch,
  lras_cfg_if.sink   cfg_ch
);
  import lras_pkg::*;

  localparam int LOG   = $clog2(SIZE);
  localparam int HW    = LOG + 1;
  localparam int IW    = (HW > 12) ? HW : 12;
  localparam int DW    = $clog2(LOG + 1);
  localparam int NODES = 2 * SIZE;

  typedef enum logic [2:0] {
    S_CLR, S_IDLE, S_READ, S_MUL, S_EVAL, S_ADV, S_FIN
  } state_t;

  state_t            state_r;
  logic [HW-1:0]     clr_r;
  logic [HW-1:0]     hk_r;      // heap node number, root = 1
  logic [DW-1:0]     depth_r;
  lras_op_t          op_r;
  logic [BND_W-1:0]  lb_r, rb_r, used_r;
  logic [VAL_W-1:0]  amt_r, tgt_r;
  logic [SUM_W-1:0]  s_r;       // running sum / range sum accumulator
  logic [IDX_W-1:0]  idx_r;
  logic              out_valid_r;
  logic [SUM_W-1:0]  out_sum_r;
  logic [IDX_W-1:0]  out_idx_r;

  // Ancestor tag sum per depth: true node sum = stored sum + tag sum * length.
  logic [SUM_W-1:0]  acc_r [LOG+1];

  logic [SUM_W-1:0]  sum_mem [NODES];
  logic [SUM_W-1:0]  tag_mem [NODES];
  logic [SUM_W-1:0]  sum_rd_r, tag_rd_r;

  logic in_acc, cfg_acc, fin_load;
  assign in_acc  = in_ch.valid && in_ch.ready;
  assign cfg_acc = cfg_ch.valid && cfg_ch.ready;

  // A pending length write wins over a command in the same cycle.
  assign in_ch.ready  = (state_r == S_IDLE) && !cfg_ch.valid;
  assign cfg_ch.ready = (state_r == S_IDLE) || (state_r == S_CLR);

  // Result register loads when the walk is done and the register is free or draining.
  assign fin_load = (state_r == S_FIN) && (op_r != OP_ADD) && (!out_valid_r || out_ch.ready);

  // ---- node geometry ----
  logic [DW-1:0] shamt;
  logic [HW-1:0] hk_sh;
  logic [IW-1:0] node_l, node_w, node_r;
  logic [IW-1:0] a_v, b_v, bl_v, used_v;
  logic [IW-1:0] hi_len, len_v, lo_o, hi_o, hi_o2, ovl_v;

  assign shamt  = DW'(LOG) - depth_r;
  assign hk_sh  = hk_r << shamt;
  assign node_l = IW'(hk_sh[LOG-1:0]);
  assign node_w = IW'(1) << shamt;
  assign node_r = node_l + node_w;
  assign a_v    = IW'(lb_r);
  assign b_v    = IW'(rb_r);
  assign bl_v   = IW'(rb_r) + IW'(1);   // leftward search bound is inclusive
  assign used_v = IW'(used_r);

  // Element count of the node, clipped to used_length.
  assign hi_len = (node_r < used_v) ? node_r : used_v;
  assign len_v  = (hi_len > node_l) ? hi_len - node_l : '0;
  // Overlap of the add range with the node, clipped to used_length.
  assign lo_o   = (a_v > node_l) ? a_v : node_l;
  assign hi_o   = (node_r < b_v) ? node_r : b_v;
  assign hi_o2  = (hi_o < used_v) ? hi_o : used_v;
  assign ovl_v  = (hi_o2 > lo_o) ? hi_o2 - lo_o : '0;

  // ---- shared multiplier ----
  logic [SUM_W-1:0] amt64, tgt64, acc_rd, mul_a, prod;
  logic [IW-1:0]    mul_b;

  assign amt64  = {{(SUM_W-VAL_W){amt_r[VAL_W-1]}}, amt_r};
  assign tgt64  = {{(SUM_W-VAL_W){tgt_r[VAL_W-1]}}, tgt_r};
  assign acc_rd = acc_r[depth_r];
  assign mul_a  = (op_r == OP_ADD) ? amt64 : acc_rd;
  assign mul_b  = (op_r == OP_ADD) ? ovl_v : len_v;

  lras_mul #(.BW(IW)) u_mul (
    .clk  (clk),
    .en_i (state_r == S_MUL),
    .a_i  (mul_a),
    .b_i  (mul_b),
    .p_o  (prod)
  );

  // ---- node evaluation ----
  logic [SUM_W-1:0] tv, v_s;
  logic             overlap, full, reach, is_leaf, leaf_hit, is_root, first;
  logic [LOG-1:0]   leaf_idx;
  logic             ev_desc, ev_found, ev_s_we;
  logic [SUM_W-1:0] ev_s;
  logic             sum_we, tag_we;
  logic [SUM_W-1:0] sum_wd, tag_wd;
  logic [HW-1:0]    mem_wa;

  assign tv       = sum_rd_r + prod;
  assign v_s      = s_r + tv;
  assign reach    = $signed(v_s) >= $signed(tgt64);
  assign overlap  = (a_v < node_r) && (node_l < b_v);
  assign full     = (a_v <= node_l) && (node_r <= b_v);
  assign is_leaf  = (depth_r == DW'(LOG));
  assign leaf_idx = hk_r[LOG-1:0];
  assign leaf_hit = (IW'(leaf_idx) != used_v);
  assign is_root  = (hk_r == HW'(1));
  // Leftward search visits right children first.
  assign first    = (op_r == OP_SEEK_L) ? hk_r[0] : !hk_r[0];

  always_comb begin
    ev_desc  = 1'b0;
    ev_found = 1'b0;
    ev_s_we  = 1'b0;
    ev_s     = s_r;
    case (op_r)
      OP_ADD: begin
        ev_desc = overlap && !full;
      end
      OP_SUM: begin
        if (overlap && full) begin
          ev_s_we = 1'b1;
          ev_s    = s_r + tv;
        end else if (overlap) begin
          ev_desc = 1'b1;
        end
      end
      OP_SEEK_R: begin
        if (node_r <= a_v) begin
          ev_s_we = 1'b1;
          ev_s    = '0;
        end else if ((a_v <= node_l) && !reach) begin
          ev_s_we = 1'b1;
          ev_s    = v_s;
        end else if (is_leaf) begin
          // leaf at index used_length does not count; walk goes on
          if (leaf_hit) begin
            ev_found = 1'b1;
          end else begin
            ev_s_we = 1'b1;
            ev_s    = v_s;
          end
        end else begin
          ev_desc = 1'b1;
        end
      end
      default: begin // OP_SEEK_L
        if (bl_v <= node_l) begin
          ev_s_we = 1'b1;
          ev_s    = '0;
        end else if ((node_r <= bl_v) && !reach) begin
          ev_s_we = 1'b1;
          ev_s    = v_s;
        end else if (is_leaf) begin
          ev_found = 1'b1;
        end else begin
          ev_desc = 1'b1;
        end
      end
    endcase
  end

  // Memory write port: clearing pass or add write-back.
  always_comb begin
    sum_we = 1'b0;
    tag_we = 1'b0;
    sum_wd = sum_rd_r + prod;
    tag_wd = tag_rd_r + amt64;
    mem_wa = hk_r;
    if (state_r == S_CLR) begin
      sum_we = 1'b1;
      tag_we = 1'b1;
      sum_wd = '0;
      tag_wd = '0;
      mem_wa = clr_r;
    end else if (state_r == S_EVAL && op_r == OP_ADD) begin
      sum_we = overlap;
      tag_we = overlap && full;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_mem[mem_wa] <= sum_wd;
    end
    if (tag_we) begin
      tag_mem[mem_wa] <= tag_wd;
    end
    sum_rd_r <= sum_mem[hk_r];
    tag_rd_r <= tag_mem[hk_r];
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      acc_r[0] <= '0;
    end else if (state_r == S_EVAL && ev_desc) begin
      acc_r[depth_r + DW'(1)] <= acc_rd + tag_rd_r;
    end
  end

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      used_r      <= USED_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ch.ready && !fin_load) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_acc) begin
        used_r  <= cfg_ch.used_length;
        clr_r   <= '0;
        state_r <= S_CLR;
      end else begin
        unique case (state_r)
          S_CLR: begin
            clr_r <= clr_r + HW'(1);
            if (clr_r == HW'(NODES - 1)) begin
              state_r <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (in_acc) begin
              op_r    <= lras_op_t'(in_ch.opcode);
              lb_r    <= in_ch.left_bound;
              rb_r    <= in_ch.right_bound;
              amt_r   <= in_ch.amount;
              tgt_r   <= in_ch.target;
              hk_r    <= HW'(1);
              depth_r <= '0;
              s_r     <= '0;
              case (lras_op_t'(in_ch.opcode))
                OP_SEEK_R: idx_r <= IDX_W'(used_r);
                OP_SEEK_L: idx_r <= '1;           // -1: not found
                default:   idx_r <= '0;
              endcase
              state_r <= S_READ;
            end
          end
          S_READ: state_r <= S_MUL;
          S_MUL:  state_r <= S_EVAL;
          S_EVAL: begin
            if (ev_s_we) begin
              s_r <= ev_s;
            end
            if (ev_found) begin
              idx_r   <= IDX_W'(leaf_idx);
              state_r <= S_FIN;
            end else if (ev_desc) begin
              hk_r    <= {hk_r[LOG-1:0], (op_r == OP_SEEK_L)};
              depth_r <= depth_r + DW'(1);
              state_r <= S_READ;
            end else begin
              state_r <= S_ADV;
            end
          end
          S_ADV: begin
            if (is_root) begin
              state_r <= S_FIN;
            end else if (first) begin
              hk_r    <= (op_r == OP_SEEK_L) ? hk_r - HW'(1) : hk_r + HW'(1);
              state_r <= S_READ;
            end else begin
              hk_r    <= hk_r >> 1;
              depth_r <= depth_r - DW'(1);
            end
          end
          S_FIN: begin
            if (op_r == OP_ADD) begin
              state_r <= S_IDLE;
            end else if (fin_load) begin
              out_valid_r <= 1'b1;
              out_sum_r   <= (op_r == OP_SUM) ? s_r : '0;
              out_idx_r   <= idx_r;
              state_r     <= S_IDLE;
            end
          end
          default: state_r <= S_IDLE;
        endcase
      end
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.sum_value   = out_sum_r;
  assign out_ch.found_index = out_idx_r;

endmodule

// ----- rtl/core/lras_mul.sv -----
// Shared multiplier with registered product, low 64 bits kept.
module lras_mul #(
  parameter int BW = 12
) (
  input  logic                       clk,
  input  logic                       en_i,
  input  logic [lras_pkg::SUM_W-1:0] a_i,
  input  logic [BW-1:0]              b_i,
  output logic [lras_pkg::SUM_W-1:0] p_o
);
  import lras_pkg::*;

  logic [SUM_W+BW-1:0] full;
  logic [SUM_W-1:0]    p_r;

  assign full = a_i * b_i;

  always_ff @(posedge clk) begin
    if (en_i) begin
      p_r <= full[SUM_W-1:0];
    end
  end

  assign p_o = p_r;
endmodule

// ----- rtl/core/lras_checker.sv -----
// Port-level checks for the lazy range tree, bound to the top level.
module lras_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [lras_pkg::SUM_W-1:0] out_sum,
  input logic [lras_pkg::IDX_W-1:0] out_idx,
  input logic                       cfg_valid,
  input logic                       cfg_ready
);
  import lras_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_busy_after_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("ready right after a command transaction");

  a_clear_after_cfg: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready |=> !in_ready)
    else $error("command taken during clearing pass");

  a_one_field: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_sum == '0 || out_idx == '0))
    else $error("both result fields nonzero");

endmodule

bind lazy_range_add_sum_tree lras_checker u_lras_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_sum   (out_ch.sum_value),
  .out_idx   (out_ch.found_index),
  .cfg_valid (cfg_ch.valid),
  .cfg_ready (cfg_ch.ready)
);

// ----- bench/lazy_range_add_sum_tree_tb_if.sv -----
`timescale 1ns / 1ps
// Testbench package: command and result transaction structs.
package lras_tb_pkg;
  import lras_pkg::*;
  typedef struct packed {
    lras_op_t                opcode;
    logic [BND_W-1:0]        left_bound;
    logic [BND_W-1:0]        right_bound;
    logic signed [VAL_W-1:0] amount;
    logic signed [VAL_W-1:0] target;
  } cmd_t;
  typedef struct packed {
    logic signed [SUM_W-1:0] sum_value;
    logic signed [IDX_W-1:0] found_index;
  } res_t;
endpackage

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// Top-level testbench: directed table plus random commands, checked against a tree predictor.
module testbench;
  import lras_pkg::*;
  import lras_tb_pkg::*;

  localparam int SIZE = 1024;
  localparam int NODES = 2 * SIZE;
  localparam longint LIMIT = 4000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  lras_in_if  in_ch ();
  lras_out_if out_ch ();
  lras_cfg_if cfg_ch ();

  lazy_range_add_sum_tree #(.SIZE(SIZE)) u_top (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  // ---- predictor state: mirror of the lazy tree (heap order, root at 0) ----
  logic [63:0] tree_sum [NODES];
  logic [63:0] tree_tag [NODES];
  int unsigned used_len;

  res_t expq [$];
  int   mism = 0;
  int   fails = 0;
  longint cyc = 0;

  function automatic int unsigned ix(int unsigned k);
    return k & (NODES - 1);
  endfunction

  function automatic logic [63:0] span(int unsigned l, int unsigned r);
    int unsigned hi;
    hi = (r < used_len) ? r : used_len;
    return (hi > l) ? 64'(hi - l) : 64'd0;
  endfunction

  function automatic bit ge_signed(logic [63:0] s, logic [63:0] t);
    return $signed(s) >= $signed(t);
  endfunction

  task automatic clear_tree();
    for (int i = 0; i < NODES; i++) begin
      tree_sum[i] = '0;
      tree_tag[i] = '0;
    end
  endtask

  // Pending tag goes to the children; the node itself absorbs tag * length.
  task automatic push(int unsigned k, int unsigned l, int unsigned r);
    logic [63:0] p;
    p = tree_tag[ix(k)];
    if (p != 0) begin
      if (k < SIZE - 1) begin
        tree_tag[ix(2*k+1)] += p;
        tree_tag[ix(2*k+2)] += p;
      end
      tree_sum[ix(k)] += p * span(l, r);
      tree_tag[ix(k)] = '0;
    end
  endtask

  task automatic add_range(int unsigned a, int unsigned b, logic [63:0] x,
                           int unsigned k, int unsigned l, int unsigned r);
    int unsigned m;
    m = (l + r) / 2;
    if (a <= l && r <= b) begin
      tree_tag[ix(k)] += x;
      push(k, l, r);
    end else if (a < r && l < b) begin
      push(k, l, r);
      add_range(a, b, x, 2*k+1, l, m);
      add_range(a, b, x, 2*k+2, m, r);
      tree_sum[ix(k)] = tree_sum[ix(2*k+1)] + tree_sum[ix(2*k+2)];
    end else begin
      push(k, l, r);
    end
  endtask

  task automatic sum_range(int unsigned a, int unsigned b, int unsigned k,
                           int unsigned l, int unsigned r, output logic [63:0] s);
    logic [63:0] s0, s1;
    int unsigned m;
    m = (l + r) / 2;
    push(k, l, r);
    if (r <= a || b <= l) s = '0;
    else if (a <= l && r <= b) s = tree_sum[ix(k)];
    else begin
      sum_range(a, b, 2*k+1, l, m, s0);
      sum_range(a, b, 2*k+2, m, r, s1);
      s = s0 + s1;
    end
  endtask

  task automatic search_right(int unsigned a, logic [63:0] t, int unsigned k,
                              int unsigned l, int unsigned r, logic [63:0] acc,
                              output int idx, output logic [63:0] acc_o);
    logic [63:0] v, xl;
    int i;
    int unsigned m;
    m = (l + r) / 2;
    push(k, l, r);
    if (r <= a) begin
      acc_o = '0; idx = int'(used_len); return;
    end
    v = acc + tree_sum[ix(k)];
    if (a <= l && !ge_signed(v, t)) begin
      acc_o = v; idx = int'(used_len); return;
    end
    if (k >= SIZE - 1) begin
      acc_o = v; idx = int'(k - (SIZE - 1)); return;
    end
    search_right(a, t, 2*k+1, l, m, acc, i, xl);
    if (i != int'(used_len)) begin
      acc_o = xl; idx = i; return;
    end
    search_right(a, t, 2*k+2, m, r, xl, idx, acc_o);
  endtask

  task automatic search_left(int unsigned b, logic [63:0] t, int unsigned k,
                             int unsigned l, int unsigned r, logic [63:0] acc,
                             output int idx, output logic [63:0] acc_o);
    logic [63:0] v, xr;
    int i;
    int unsigned m;
    m = (l + r) / 2;
    push(k, l, r);
    if (b <= l) begin
      acc_o = '0; idx = -1; return;
    end
    v = tree_sum[ix(k)] + acc;
    if (r <= b && !ge_signed(v, t)) begin
      acc_o = v; idx = -1; return;
    end
    if (k >= SIZE - 1) begin
      acc_o = v; idx = int'(k - (SIZE - 1)); return;
    end
    search_left(b, t, 2*k+2, m, r, acc, i, xr);
    if (i != -1) begin
      acc_o = xr; idx = i; return;
    end
    search_left(b, t, 2*k+1, l, m, xr, idx, acc_o);
  endtask

  // Apply one command to the mirror; returns 1 with the predicted result if one is due.
  task automatic predict(cmd_t c, output bit has, output res_t res);
    logic [63:0] s, tgt, dummy;
    int idx;
    tgt = 64'(c.target);
    res = '0;
    has = 1'b1;
    case (c.opcode)
      OP_ADD: begin
        add_range(c.left_bound, c.right_bound, 64'(c.amount), 0, 0, SIZE);
        has = 1'b0;
      end
      OP_SUM: begin
        sum_range(c.left_bound, c.right_bound, 0, 0, SIZE, s);
        res.sum_value = s;
      end
      OP_SEEK_R: begin
        search_right(c.left_bound, tgt, 0, 0, SIZE, '0, idx, dummy);
        res.found_index = idx[IDX_W-1:0];
      end
      default: begin
        search_left(c.right_bound + 1, tgt, 0, 0, SIZE, '0, idx, dummy);
        res.found_index = idx[IDX_W-1:0];
      end
    endcase
  endtask

  // ---- driving (falling edge), sampling (rising edge) ----
  initial begin
    in_ch.valid = 0; in_ch.opcode = OP_ADD; in_ch.left_bound = 0; in_ch.right_bound = 0;
    in_ch.amount = 0; in_ch.target = 0;
    out_ch.ready = 0;
    cfg_ch.valid = 0; cfg_ch.used_length = 0;
  end

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
  endfunction

  // Sink side: random stalls, now and then a long one; phases with no stall.
  bit no_stall = 0;
  int stall_left = 0;
  always @(negedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else if (no_stall) out_ch.ready <= 1'b1;
    else if (stall_left > 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 39) == 0) begin
      stall_left = $urandom_range(10, 60);
      out_ch.ready <= 1'b0;
    end else out_ch.ready <= ($urandom_range(0, 9) < 7);
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expq.size() == 0) begin
        fails++;
        if (mism < 10) $display("unexpected result transaction sum=%0d idx=%0d",
                                out_ch.sum_value, out_ch.found_index);
        mism++;
      end else begin
        res_t e;
        e = expq.pop_front();
        if (e.sum_value !== out_ch.sum_value || e.found_index !== out_ch.found_index) begin
          fails++;
          if (mism < 10)
            $display("mismatch: exp sum=%0d idx=%0d, got sum=%0d idx=%0d",
                     e.sum_value, e.found_index, out_ch.sum_value, out_ch.found_index);
          mism++;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    wait (cyc >= LIMIT);
    $display("lazy_range_add_sum_tree test failed");
    $finish;
  end

  // Send one command at a falling edge; the predictor runs when the transaction is accepted.
  task automatic send(cmd_t c);
    bit has;
    res_t r;
    in_ch.valid = 1'b1;
    in_ch.opcode = c.opcode; in_ch.left_bound = c.left_bound;
    in_ch.right_bound = c.right_bound; in_ch.amount = c.amount; in_ch.target = c.target;
    do @(posedge clk); while (!in_ch.ready);
    predict(c, has, r);
    if (has) expq.push_back(r);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic send_gap(cmd_t c);
    int g;
    g = gap_len();
    repeat (g) @(negedge clk);
    send(c);
  endtask

  // Wait until every result has come and the block is idle again.
  task automatic drain();
    while (expq.size() != 0 || !in_ch.ready) @(negedge clk);
  endtask

  task automatic write_len(logic [BND_W-1:0] v);
    cfg_ch.valid = 1'b1;
    cfg_ch.used_length = v;
    do @(posedge clk); while (!cfg_ch.ready);
    used_len = v;
    clear_tree();
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic cmd_t mk(lras_op_t o, int l, int r, int a, int t);
    cmd_t c;
    c.opcode = o; c.left_bound = l[BND_W-1:0]; c.right_bound = r[BND_W-1:0];
    c.amount = a; c.target = t;
    return c;
  endfunction

  // Bounds mostly inside the used part, with some reaching the clipped region.
  function automatic cmd_t rand_cmd();
    cmd_t c;
    int unsigned lim, a, b;
    lim = (used_len == 0) ? 1 : used_len;
    c.opcode = lras_op_t'($urandom_range(0, 3));
    if ($urandom_range(0, 15) == 0) begin
      a = $urandom_range(0, 2047); b = $urandom_range(0, 2047);
    end else begin
      a = $urandom_range(0, lim); b = $urandom_range(0, lim);
      if (a > b && $urandom_range(0, 5) != 0) begin
        int unsigned t; t = a; a = b; b = t;
      end
    end
    c.left_bound = a[BND_W-1:0]; c.right_bound = b[BND_W-1:0];
    case ($urandom_range(0, 3))
      0: c.amount = $urandom();
      1: c.amount = 32'sd0 - 32'($urandom_range(0, 100));
      default: c.amount = $urandom_range(0, 100);
    endcase
    case ($urandom_range(0, 3))
      0: c.target = $urandom();
      1: c.target = 32'sd0 - 32'($urandom_range(0, 2000));
      default: c.target = $urandom_range(0, 5000);
    endcase
    return c;
  endfunction

  // Directed rows; expected result given only where obvious (all-zero array after reset).
  typedef struct {
    cmd_t c;
    bit   known;
    res_t r;
  } row_t;

  initial begin
    row_t rows [$];
    row_t rw;
    bit has;
    res_t r;
    logic [BND_W-1:0] lens [5];
    used_len = USED_RST;
    clear_tree();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Zero array: sum is zero, searches for target 1 find nothing.
    rw.known = 1; rw.c = mk(OP_SUM, 0, 1024, 0, 0); rw.r = '0; rows.push_back(rw);
    rw.c = mk(OP_SEEK_R, 0, 0, 0, 1); rw.r = '0; rw.r.found_index = 1024; rows.push_back(rw);
    rw.c = mk(OP_SEEK_L, 0, 1023, 0, 1); rw.r = '0; rw.r.found_index = -1; rows.push_back(rw);
    rw.known = 0;
    rw.c = mk(OP_ADD, 0, 1024, 32'h7fffffff, 0); rows.push_back(rw);
    rw.c = mk(OP_ADD, 0, 2047, 32'h80000000, 0); rows.push_back(rw);
    rw.c = mk(OP_ADD, 5, 5, 77, 0); rows.push_back(rw);            // empty range
    rw.c = mk(OP_ADD, 9, 3, 77, 0); rows.push_back(rw);            // reversed range
    rw.c = mk(OP_ADD, 1000, 2047, 12345, 0); rows.push_back(rw);   // clipped end
    rw.c = mk(OP_SUM, 0, 2047, 0, 0); rows.push_back(rw);
    rw.c = mk(OP_SUM, 1023, 1024, 0, 0); rows.push_back(rw);
    rw.c = mk(OP_SUM, 9, 3, 0, 0); rows.push_back(rw);
    rw.c = mk(OP_SEEK_R, 0, 0, 0, 32'h80000000); rows.push_back(rw);
    rw.c = mk(OP_SEEK_R, 2047, 0, 0, 32'h7fffffff); rows.push_back(rw);
    rw.c = mk(OP_SEEK_R, 10, 0, 0, 32'h7fffffff); rows.push_back(rw);
    rw.c = mk(OP_SEEK_L, 0, 2047, 0, 32'h80000000); rows.push_back(rw);
    rw.c = mk(OP_SEEK_L, 0, 0, 0, 32'h7fffffff); rows.push_back(rw);
    rw.c = mk(OP_SEEK_L, 2047, 500, 0, -5); rows.push_back(rw);

    foreach (rows[i]) begin
      if (rows[i].known) begin
        // The table value must agree with the predictor; send() then queues it.
        predict(rows[i].c, has, r);
        if (r !== rows[i].r) begin
          fails++;
          $display("table row %0d disagrees with predictor", i);
        end
        used_len = USED_RST; clear_tree(); // zero array again, no adds applied yet
      end
      send_gap(rows[i].c);
    end
    drain();

    // Length settings: extremes and middles; each write restarts from zero.
    lens[0] = 11'd1; lens[1] = 11'd1024; lens[2] = 11'd2; lens[3] = 11'd37; lens[4] = 11'd700;
    foreach (lens[p]) begin
      write_len(lens[p]);
      no_stall = (p == 1);
      for (int n = 0; n < 330; n++) begin
        if (n == 160) while (expq.size() != 0) @(negedge clk);
        if (no_stall && n < 100) send(rand_cmd());
        else send_gap(rand_cmd());
      end
      drain();
    end
    no_stall = 0;
    if (fails == 0) $display("lazy_range_add_sum_tree test passed");
    else $display("lazy_range_add_sum_tree test failed");
    $finish;
  end
endmodule
